FILE: hdl/assert_macros.svh
// Assertion helper macros for the cache RTL.
// Included by modules that carry concurrent checks; expects aclk and aresetn in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define DMWB_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define DMWB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/dmwb_pkg.sv
// Shared types and constants for the direct-mapped write-back cache.
// No dependencies; imported by the cache top level and the testbench.
`timescale 1ns / 1ps

package dmwb_pkg;

    localparam int DMWB_LINE_BYTES = 16;
    localparam int DMWB_LINES      = 16;
    localparam int DMWB_ADDR_BITS  = 12;

    // item field widths
    localparam int OP_W         = 2;
    localparam int ADDR_FIELD_W = 12;
    localparam int DATA_W       = 8;
    localparam int S_TDATA_W    = 24;
    localparam int M_TDATA_W    = 24;

    // operation codes; code 3 is unused and does nothing
    typedef enum logic [OP_W-1:0] {
        OP_READ    = 2'd0,
        OP_WRITE   = 2'd1,
        OP_PRELOAD = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_WB,
        ST_FILL,
        ST_DONE
    } state_t;

endpackage

FILE: hdl/dmwb_ram.sv
// Simple dual-port synchronous RAM: one write port, one read port, registered read.
// Standalone; used for the backing store, line data and tag arrays.
`timescale 1ns / 1ps

module dmwb_ram #(
    parameter int AW = 4,
    parameter int DW = 8
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] mem [2**AW];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

FILE: hdl/direct_mapped_writeback_cache.sv
// Channel   Dir  tdata (low bit up)                                 tuser
// s_        in   address[11:0], write_data[19:12], pad               operation[1:0]
// m_        out  read_data[7:0], hit[8], wrote_back[9],
//                victim_base[21:10], pad                             -
//
// One item at a time. A hit goes from lookup straight to the result; a clean miss fills the line first.
// A dirty miss does the victim copy-out, then the line fill, one byte a cycle.
// Preload and the unused op code go from lookup straight to the result. The next item is taken in the result cycle.
// After reset a clearing pass zeroes all 2**ADDR_BITS bytes of the backing store, with s_tready low.
// A waiting result in the m_ output register stalls only the following item's result cycle.
// Depends on dmwb_pkg, dmwb_ram and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module direct_mapped_writeback_cache
    import dmwb_pkg::*;
#(
    parameter int LINE_BYTES = DMWB_LINE_BYTES,  // power of two
    parameter int LINES      = DMWB_LINES,       // power of two
    parameter int ADDR_BITS  = DMWB_ADDR_BITS
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // address, write_data, zero pad
    input  logic [OP_W-1:0]      s_tuser,   // operation

    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // read_data, hit, wrote_back, victim_base, pad
);

    localparam int OFF_W   = $clog2(LINE_BYTES);
    localparam int IDX_W   = $clog2(LINES);
    localparam int TAG_RAW = ADDR_BITS - OFF_W - IDX_W;
    localparam int TAG_W   = (TAG_RAW > 0) ? TAG_RAW : 1;
    localparam int WIDE_W  = OFF_W + IDX_W + TAG_W;
    localparam int LADDR_W = IDX_W + OFF_W;
    localparam int CNT_W   = OFF_W + 1;

    state_t                 state_reg, state_next;
    logic [ADDR_BITS-1:0]   clr_reg, clr_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [LINES-1:0]       valid_reg, valid_next;
    logic [LINES-1:0]       dirty_reg, dirty_next;

    logic [OP_W-1:0]        op_reg, op_next;
    logic [ADDR_BITS-1:0]   addr_reg, addr_next;
    logic [DATA_W-1:0]      wdata_reg, wdata_next;
    logic [TAG_W-1:0]       vtag_reg, vtag_next;

    logic [DATA_W-1:0]       res_rd_reg, res_rd_next;
    logic                    res_hit_reg, res_hit_next;
    logic                    res_wb_reg, res_wb_next;
    logic [ADDR_FIELD_W-1:0] res_vb_reg, res_vb_next;

    logic                   m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0]   m_data_reg, m_data_next;

    // incoming address split
    logic [ADDR_BITS-1:0]   in_addr;
    logic [WIDE_W-1:0]      in_wide;
    logic [IDX_W-1:0]       in_idx;
    logic [OFF_W-1:0]       in_off;

    // latched address split
    logic [WIDE_W-1:0]      cur_wide;
    logic [IDX_W-1:0]       cur_idx;
    logic [OFF_W-1:0]       cur_off;
    logic [TAG_W-1:0]       cur_tag;

    // copy-out / fill byte positions
    logic [OFF_W-1:0]       rd_off;
    logic [OFF_W-1:0]       wr_off;
    logic [WIDE_W-1:0]      vic_base_wide;
    logic [WIDE_W-1:0]      vic_wr_wide;
    logic [ADDR_BITS-1:0]   vic_base_addr;
    logic                   out_free;

    // memory ports
    logic                   bk_we;
    logic [ADDR_BITS-1:0]   bk_waddr, bk_raddr;
    logic [DATA_W-1:0]      bk_wdata, bk_rdata;
    logic                   ln_we;
    logic [LADDR_W-1:0]     ln_waddr, ln_raddr;
    logic [DATA_W-1:0]      ln_wdata, ln_rdata;
    logic                   tg_we;
    logic [IDX_W-1:0]       tg_waddr, tg_raddr;
    logic [TAG_W-1:0]       tg_wdata, tg_rdata;

    // check terms
    logic                   idle_or_done;
    logic                   fill_last;
    logic                   dirty_orphan;

    assign in_addr = ADDR_BITS'(s_tdata[ADDR_FIELD_W-1:0]);
    assign in_wide = WIDE_W'(in_addr);
    assign in_idx  = in_wide[OFF_W +: IDX_W];
    assign in_off  = in_wide[OFF_W-1:0];

    assign cur_wide = WIDE_W'(addr_reg);
    assign cur_idx  = cur_wide[OFF_W +: IDX_W];
    assign cur_off  = cur_wide[OFF_W-1:0];
    assign cur_tag  = cur_wide[WIDE_W-1 -: TAG_W];

    assign rd_off = cnt_reg[OFF_W-1:0];
    assign wr_off = OFF_W'(cnt_reg - 1'b1);

    assign vic_base_wide = {tg_rdata, cur_idx, {OFF_W{1'b0}}};
    assign vic_base_addr = vic_base_wide[ADDR_BITS-1:0];
    assign vic_wr_wide   = {vtag_reg, cur_idx, wr_off};

    assign out_free = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;

    dmwb_ram #(.AW(ADDR_BITS), .DW(DATA_W)) u_backing (
        .aclk    (aclk),
        .wr_en   (bk_we),
        .wr_addr (bk_waddr),
        .wr_data (bk_wdata),
        .rd_addr (bk_raddr),
        .rd_data (bk_rdata)
    );

    dmwb_ram #(.AW(LADDR_W), .DW(DATA_W)) u_lines (
        .aclk    (aclk),
        .wr_en   (ln_we),
        .wr_addr (ln_waddr),
        .wr_data (ln_wdata),
        .rd_addr (ln_raddr),
        .rd_data (ln_rdata)
    );

    dmwb_ram #(.AW(IDX_W), .DW(TAG_W)) u_tags (
        .aclk    (aclk),
        .wr_en   (tg_we),
        .wr_addr (tg_waddr),
        .wr_data (tg_wdata),
        .rd_addr (tg_raddr),
        .rd_data (tg_rdata)
    );

    always_comb begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        cnt_next      = cnt_reg;
        valid_next    = valid_reg;
        dirty_next    = dirty_reg;
        op_next       = op_reg;
        addr_next     = addr_reg;
        wdata_next    = wdata_reg;
        vtag_next     = vtag_reg;
        res_rd_next   = res_rd_reg;
        res_hit_next  = res_hit_reg;
        res_wb_next   = res_wb_reg;
        res_vb_next   = res_vb_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_data_next   = m_data_reg;
        s_tready      = 1'b0;

        bk_we    = 1'b0;
        bk_waddr = addr_reg;
        bk_wdata = wdata_reg;
        bk_raddr = {addr_reg[ADDR_BITS-1:OFF_W], rd_off};
        ln_we    = 1'b0;
        ln_waddr = {cur_idx, wr_off};
        ln_wdata = bk_rdata;
        // lookup reads are issued in the cycle the item is taken
        ln_raddr = {in_idx, in_off};
        tg_we    = 1'b0;
        tg_waddr = cur_idx;
        tg_wdata = cur_tag;
        tg_raddr = in_idx;

        case (state_reg)
            ST_CLEAR: begin
                bk_we    = 1'b1;
                bk_waddr = clr_reg;
                bk_wdata = '0;
                clr_next = clr_reg + 1'b1;
                if (&clr_reg) begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    op_next    = s_tuser;
                    addr_next  = in_addr;
                    wdata_next = s_tdata[ADDR_FIELD_W +: DATA_W];
                    state_next = ST_LOOKUP;
                end
            end

            ST_LOOKUP: begin
                res_rd_next  = '0;
                res_hit_next = 1'b0;
                res_wb_next  = 1'b0;
                res_vb_next  = '0;
                vtag_next    = tg_rdata;
                cnt_next     = '0;
                state_next   = ST_DONE;
                case (op_reg)
                    OP_PRELOAD: begin
                        bk_we = 1'b1;
                    end
                    OP_READ, OP_WRITE: begin
                        if (valid_reg[cur_idx] && tg_rdata == cur_tag) begin
                            res_hit_next = 1'b1;
                            if (op_reg == OP_READ) begin
                                res_rd_next = ln_rdata;
                            end else begin
                                ln_we               = 1'b1;
                                ln_waddr            = {cur_idx, cur_off};
                                ln_wdata            = wdata_reg;
                                dirty_next[cur_idx] = 1'b1;
                            end
                        end else if (valid_reg[cur_idx] && dirty_reg[cur_idx]) begin
                            res_wb_next = 1'b1;
                            res_vb_next = ADDR_FIELD_W'(vic_base_addr);
                            state_next  = ST_WB;
                        end else begin
                            state_next = ST_FILL;
                        end
                    end
                    default: begin
                    end
                endcase
            end

            // copy victim out: read byte k, write byte k-1 to backing store
            ST_WB: begin
                ln_raddr = {cur_idx, rd_off};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg != '0) begin
                    bk_we    = 1'b1;
                    bk_waddr = vic_wr_wide[ADDR_BITS-1:0];
                    bk_wdata = ln_rdata;
                end
                if (cnt_reg == CNT_W'(LINE_BYTES)) begin
                    cnt_next   = '0;
                    state_next = ST_FILL;
                end
            end

            // fill line; the accessed byte is merged or captured on the fly
            ST_FILL: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg != '0) begin
                    ln_we = 1'b1;
                    if (wr_off == cur_off) begin
                        if (op_reg == OP_WRITE) begin
                            ln_wdata = wdata_reg;
                        end else begin
                            res_rd_next = bk_rdata;
                        end
                    end
                end
                if (cnt_reg == CNT_W'(LINE_BYTES)) begin
                    tg_we               = 1'b1;
                    valid_next[cur_idx] = 1'b1;
                    dirty_next[cur_idx] = (op_reg == OP_WRITE);
                    state_next          = ST_DONE;
                end
            end

            ST_DONE: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_data_next   = M_TDATA_W'({res_vb_reg, res_wb_reg, res_hit_reg, res_rd_reg});
                    s_tready      = 1'b1;
                    state_next    = ST_IDLE;
                    if (s_tvalid) begin
                        op_next    = s_tuser;
                        addr_next  = in_addr;
                        wdata_next = s_tdata[ADDR_FIELD_W +: DATA_W];
                        state_next = ST_LOOKUP;
                    end
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_reg      <= '0;
            cnt_reg      <= '0;
            valid_reg    <= '0;
            dirty_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            cnt_reg      <= cnt_next;
            valid_reg    <= valid_next;
            dirty_reg    <= dirty_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg      <= op_next;
        addr_reg    <= addr_next;
        wdata_reg   <= wdata_next;
        vtag_reg    <= vtag_next;
        res_rd_reg  <= res_rd_next;
        res_hit_reg <= res_hit_next;
        res_wb_reg  <= res_wb_next;
        res_vb_reg  <= res_vb_next;
        m_data_reg  <= m_data_next;
    end

    assign idle_or_done = (state_reg == ST_IDLE) || (state_reg == ST_DONE);
    assign fill_last    = (state_reg == ST_FILL) && (cnt_reg == CNT_W'(LINE_BYTES));
    assign dirty_orphan = |(dirty_reg & ~valid_reg);

    // a written-back victim only ever comes with a miss
    `DMWB_ASSERT_IMPL(a_wb_not_hit, m_tvalid && m_tdata[9], !m_tdata[8], "writeback on a hit")

    // items are only taken when no other item is in flight
    `DMWB_ASSERT_IMPL(a_accept_free, s_tvalid && s_tready, idle_or_done, "item taken while busy")

    // finishing a fill leaves the line valid
    `DMWB_ASSERT_NEXT(a_fill_valid, fill_last, valid_reg[cur_idx], "line not valid after fill")

    // a dirty line must also be valid
    `DMWB_ASSERT_IMPL(a_dirty_valid, state_reg == ST_LOOKUP, !dirty_orphan, "dirty line not valid")

endmodule

FILE: sim/tb_top.sv
// Self-checking testbench for direct_mapped_writeback_cache: stream driver, monitor, cache model.
// Depends on dmwb_pkg and the cache RTL; no files or arguments needed.
`timescale 1ns / 1ps

module tb_top
    import dmwb_pkg::*;
();

    localparam int OFF_W = $clog2(DMWB_LINE_BYTES);
    localparam int IDX_W = $clog2(DMWB_LINES);
    localparam int TAG_W = DMWB_ADDR_BITS - OFF_W - IDX_W;
    localparam int MEM_BYTES = 1 << DMWB_ADDR_BITS;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 800;

    typedef struct {
        logic [OP_W-1:0]         op;
        logic [ADDR_FIELD_W-1:0] addr;
        logic [DATA_W-1:0]       wdata;
        bit                      drain;  // wait for all results before sending
    } cache_req_t;

    typedef struct packed {
        logic [DATA_W-1:0]       rdata;
        logic                    hit;
        logic                    wrote_back;
        logic [ADDR_FIELD_W-1:0] victim_base;
    } cache_resp_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;   // address, write_data, zero pad
    logic [OP_W-1:0]      s_tuser = '0;   // operation

    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;    // read_data, hit, wrote_back, victim_base, pad

    direct_mapped_writeback_cache DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // cache model state
    logic                line_ok   [DMWB_LINES];
    logic                line_mod  [DMWB_LINES];
    logic [TAG_W-1:0]    line_tg   [DMWB_LINES];
    logic [DATA_W-1:0]   line_data [DMWB_LINES*DMWB_LINE_BYTES];
    logic [DATA_W-1:0]   mem_model [MEM_BYTES];

    cache_req_t  req_q[$];
    cache_resp_t resp_q[$];

    cache_req_t  s_req;
    cache_req_t  nxt_req;
    cache_resp_t got;
    cache_resp_t want;
    logic        s_taken = 1'b0;
    logic        m_taken = 1'b0;
    logic        rx_hold = 1'b0;
    int          tx_wait = 0;
    int          tx_calm = 0;
    int          rx_wait = 0;
    int          rx_calm = 0;
    int          fail_count = 0;
    int          results_seen = 0;

    initial begin
        for (int i = 0; i < DMWB_LINES; i++) begin
            line_ok[i] = 1'b0;
            line_mod[i] = 1'b0;
            line_tg[i] = '0;
        end
        foreach (line_data[i]) line_data[i] = '0;
        foreach (mem_model[i]) mem_model[i] = '0;
    end

    // One cache access: updates the model and returns the result item.
    function automatic cache_resp_t cache_access(cache_req_t rq);
        cache_resp_t r;
        logic [OFF_W-1:0]          off;
        logic [IDX_W-1:0]          idx;
        logic [TAG_W-1:0]          tg;
        logic [DMWB_ADDR_BITS-1:0] base;
        logic [DMWB_ADDR_BITS-1:0] vb;
        int                        lb;
        r = '0;
        off = rq.addr[OFF_W-1:0];
        idx = rq.addr[OFF_W +: IDX_W];
        tg = rq.addr[OFF_W+IDX_W +: TAG_W];
        lb = int'(idx) * DMWB_LINE_BYTES;
        if (rq.op == OP_PRELOAD) begin
            mem_model[rq.addr[DMWB_ADDR_BITS-1:0]] = rq.wdata;
        end else if (rq.op == OP_READ || rq.op == OP_WRITE) begin
            if (line_ok[idx] && line_tg[idx] == tg) begin
                r.hit = 1'b1;
            end else begin
                base = {tg, idx, {OFF_W{1'b0}}};
                if (line_ok[idx] && line_mod[idx]) begin
                    vb = {line_tg[idx], idx, {OFF_W{1'b0}}};
                    for (int i = 0; i < DMWB_LINE_BYTES; i++)
                        mem_model[DMWB_ADDR_BITS'(vb + i)] = line_data[lb + i];
                    r.wrote_back = 1'b1;
                    r.victim_base = ADDR_FIELD_W'(vb);
                end
                for (int i = 0; i < DMWB_LINE_BYTES; i++)
                    line_data[lb + i] = mem_model[DMWB_ADDR_BITS'(base + i)];
                line_ok[idx] = 1'b1;
                line_mod[idx] = 1'b0;
                line_tg[idx] = tg;
            end
            if (rq.op == OP_READ) begin
                r.rdata = line_data[lb + int'(off)];
            end else begin
                line_data[lb + int'(off)] = rq.wdata;
                line_mod[idx] = 1'b1;
            end
        end
        return r;
    endfunction

    // Per-item wait, with occasional runs of back-to-back items.
    function automatic int pick_wait(inout int calm_left);
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 39) == 0) calm_left = $urandom_range(10, 40);
        return $urandom_range(0, 11);
    endfunction

    // four-state compare so unknown bits count as a mismatch
    function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            fail_count++;
        end
    endfunction

    task automatic add_req(logic [OP_W-1:0] op, logic [ADDR_FIELD_W-1:0] addr,
                           logic [DATA_W-1:0] wdata, bit drain);
        cache_req_t rq;
        rq.op = op;
        rq.addr = addr;
        rq.wdata = wdata;
        rq.drain = drain;
        req_q.push_back(rq);
    endtask

    // driver: capture accepted items at the rising edge, drive at the falling edge
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            resp_q.push_back(cache_access(s_req));
            s_taken <= 1'b1;
        end else begin
            s_taken <= 1'b0;
        end
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_taken) begin
            if (s_taken) tx_wait = pick_wait(tx_calm);
            if (tx_wait > 0) begin
                s_tvalid <= 1'b0;
                tx_wait--;
            end else if (req_q.size() == 0 || (req_q[0].drain && resp_q.size() != 0)) begin
                s_tvalid <= 1'b0;
            end else begin
                nxt_req = req_q.pop_front();
                s_req <= nxt_req;
                s_tdata <= {{(S_TDATA_W-ADDR_FIELD_W-DATA_W){1'b0}}, nxt_req.wdata,
                            nxt_req.addr};
                s_tuser <= nxt_req.op;
                s_tvalid <= 1'b1;
            end
        end
    end

    // monitor: check results at the rising edge, drive ready at the falling edge
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            m_taken <= 1'b1;
            got.rdata = m_tdata[7:0];
            got.hit = m_tdata[8];
            got.wrote_back = m_tdata[9];
            got.victim_base = m_tdata[21:10];
            if (resp_q.size() == 0) begin
                $error("result item with nothing expected: m_tdata=0x%0h", m_tdata);
                fail_count++;
            end else begin
                want = resp_q.pop_front();
                check_field("read_data", want.rdata, got.rdata);
                check_field("hit", want.hit, got.hit);
                check_field("wrote_back", want.wrote_back, got.wrote_back);
                check_field("victim_base", want.victim_base, got.victim_base);
                results_seen++;
            end
        end else begin
            m_taken <= 1'b0;
        end
    end

    always @(negedge aclk) begin
        if (m_taken) rx_wait = pick_wait(rx_calm);
        if (rx_hold) begin
            m_tready <= 1'b0;
        end else if (rx_wait > 0) begin
            m_tready <= 1'b0;
            rx_wait--;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // long receiver stall so the block backs up while items keep coming
    initial begin
        while (results_seen < 150) @(posedge aclk);
        @(negedge aclk);
        rx_hold <= 1'b1;
        repeat (300) @(negedge aclk);
        rx_hold <= 1'b0;
    end

    initial begin
        #1_000_000;
        $display("tb_top failed");
        $finish;
    end

    initial begin
        cache_req_t rq;
        int         pick;
        // directed: clean miss, preload and stale copy, dirty evictions, address extremes
        add_req(OP_READ,    12'h000, 8'h00, 1'b0);
        add_req(OP_PRELOAD, 12'h123, 8'hA5, 1'b0);
        add_req(OP_READ,    12'h123, 8'h00, 1'b0);
        add_req(OP_PRELOAD, 12'h123, 8'h5A, 1'b0);
        add_req(OP_READ,    12'h123, 8'hFF, 1'b0);  // hit on stale line
        add_req(OP_WRITE,   12'h12F, 8'hFF, 1'b0);
        add_req(OP_READ,    12'h22F, 8'h00, 1'b0);  // evicts dirty line at 0x120
        add_req(OP_READ,    12'h12F, 8'h00, 1'b0);
        add_req(OP_WRITE,   12'hFFF, 8'h00, 1'b0);
        add_req(OP_WRITE,   12'hFF0, 8'hFF, 1'b0);
        add_req(OP_READ,    12'h0F5, 8'h00, 1'b0);  // victim at the top of memory
        add_req(OP_UNUSED,  12'hFFF, 8'hFF, 1'b0);
        add_req(OP_UNUSED,  12'h000, 8'h00, 1'b0);
        add_req(OP_PRELOAD, 12'h000, 8'hFF, 1'b1);
        add_req(OP_READ,    12'h000, 8'h00, 1'b0);
        add_req(OP_WRITE,   12'h000, 8'h3C, 1'b0);
        add_req(OP_READ,    12'h100, 8'h00, 1'b0);  // victim base zero
        add_req(OP_READ,    12'h000, 8'h00, 1'b0);
        add_req(OP_WRITE,   12'h7AA, 8'h55, 1'b0);
        add_req(OP_READ,    12'h7AA, 8'h00, 1'b0);
        add_req(OP_PRELOAD, 12'hFFF, 8'h81, 1'b0);
        add_req(OP_READ,    12'hEFF, 8'h00, 1'b0);

        // random: a few hot lines and tags so hits and dirty conflicts are common
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 45)      rq.op = OP_READ;
            else if (pick < 85) rq.op = OP_WRITE;
            else if (pick < 97) rq.op = OP_PRELOAD;
            else                rq.op = OP_UNUSED;
            rq.addr = ADDR_FIELD_W'($urandom);
            if ($urandom_range(0, 7) != 0) begin
                rq.addr[OFF_W+IDX_W +: TAG_W] = TAG_W'($urandom_range(0, 2));
                rq.addr[OFF_W +: IDX_W] = IDX_W'($urandom_range(0, 3));
            end
            rq.wdata = DATA_W'($urandom);
            rq.drain = (n % 200 == 0);
            req_q.push_back(rq);
        end

        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;

        while (req_q.size() != 0 || s_tvalid) @(posedge aclk);
        while (resp_q.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (fail_count == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
